### rtl/core/kps_pkg.sv
// shared types and constants for the matrix keypad scanner
`default_nettype none

package kps_pkg;

	localparam int ROWS = 4;
	localparam int COLS = 4;

	localparam int ROW_W = 2;
	localparam int COL_W = 2;
	localparam int SAMPLE_W = 4;
	localparam int CNT_W = 3;

	localparam logic [CNT_W-1:0] COL_COUNT_RESET = CNT_W'(4);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << COLS) - 1);

	typedef struct packed {
		logic                tick;
		logic [SAMPLE_W-1:0] col_sample;
	} poll_word_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_drive;
		logic             event_valid;
		logic             key_down;
		logic [ROW_W-1:0] event_row;
		logic [COL_W-1:0] event_col;
		logic             last;
	} evt_word_t;

	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [SAMPLE_W-1:0] change;
		logic [SAMPLE_W-1:0] sample;
	} pend_t;

endpackage

`default_nettype wire

### rtl/core/kps_emit.sv
// pending register and output register that emit one event word per cycle while evt_ready holds
`default_nettype none

module kps_emit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take_valid,
	input  wire kps_pkg::pend_t take,
	output logic               take_ready,
	output logic               evt_valid,
	input  wire logic          evt_ready,
	output kps_pkg::evt_word_t evt
);
	import kps_pkg::*;

	logic             pend_valid_s1;
	pend_t            pend_s1;
	logic             out_valid_q;
	evt_word_t        out_q;
	logic             load;
	logic             found;
	logic [COL_W-1:0] sel;
	logic [SAMPLE_W-1:0] rest;
	logic             fin;

	// lowest changed column first
	always_comb begin
		sel = '0;
		for (int i = COLS - 1; i >= 0; i--) begin
			if (pend_s1.change[i]) begin
				sel = COL_W'(i);
			end
		end
		found = |pend_s1.change;
		rest = pend_s1.change;
		if (found) begin
			rest[sel] = 1'b0;
		end
	end

	assign load = !out_valid_q || evt_ready;
	assign fin = load && pend_valid_s1 && (rest == '0);
	assign take_ready = !pend_valid_s1 || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_ready) begin
				pend_valid_s1 <= take_valid;
			end
			if (load) begin
				out_valid_q <= pend_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_ready && take_valid) begin
			pend_s1 <= take;
		end else if (load && pend_valid_s1) begin
			pend_s1.change <= rest;
		end
		if (load && pend_valid_s1) begin
			out_q.row_drive <= pend_s1.row;
			out_q.event_valid <= found;
			out_q.key_down <= found && pend_s1.sample[sel];
			out_q.event_row <= found ? pend_s1.row : '0;
			out_q.event_col <= sel;
			out_q.last <= (rest == '0);
		end
	end

	assign evt_valid = out_valid_q;
	assign evt = out_q;

	a_idle_word_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.event_valid |-> out_q.last)
		else $error("word without event is not marked last");

	a_event_row_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.event_valid |-> out_q.event_row == out_q.row_drive)
		else $error("event row differs from driven row");

	a_no_event_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.event_valid |-> out_q.event_col == '0)
		else $error("column set on word without event");

	a_pending_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_s1 && load && !take_ready |=> pend_valid_s1 && out_valid_q)
		else $error("pending poll lost before its last word");

endmodule

`default_nettype wire

### rtl/core/matrix_keypad_scanner_unit.sv
// top level of the matrix keypad scanner: scan sequencing, key store and event emission
`default_nettype none

// Each poll word drives the scan sequence one step (stabilise, wait for tick, read until
// two reads agree) and returns one or more event words. A poll that changes no enabled
// key gives one word without event, marked last; a poll that completes a row gives one
// word per changed enabled column, lowest column first, the final one marked last. The
// block takes one poll per cycle while no events are pending and the output is not stalled;
// a poll with N events holds the next poll until its last event word is loaded, since the
// single output register sends one event per cycle while evt_ready is high. The key store
// is cleared at reset directly. col_count may be written only while no poll is in flight.
module matrix_keypad_scanner_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        poll_valid,
	output logic                             poll_ready,
	input  wire kps_pkg::poll_word_t         poll,
	output logic                             evt_valid,
	input  wire logic                        evt_ready,
	output kps_pkg::evt_word_t               evt,
	input  wire logic                        cfg_we,
	input  wire logic [kps_pkg::CNT_W-1:0]   cfg_wdata
);
	import kps_pkg::*;

	typedef enum logic [1:0] {
		PH_STAB = 2'd0,
		PH_WAIT = 2'd1,
		PH_READ = 2'd2
	} phase_t;

	phase_t              phase_q;
	phase_t              phase_d;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_W-1:0]    row_next;
	logic [SAMPLE_W-1:0] prev_q;
	logic                prev_valid_q;
	logic [SAMPLE_W-1:0] key_q [ROWS];
	logic [CNT_W-1:0]    col_count_q;
	logic [CNT_W-1:0]    lim;
	logic [SAMPLE_W-1:0] en_mask;
	logic [SAMPLE_W-1:0] sample;
	logic                accept;
	logic                match;
	logic                done_row;
	pend_t               take;

	assign accept = poll_valid && poll_ready;
	assign sample = poll.col_sample & SAMPLE_MASK;
	assign match = prev_valid_q && (sample == prev_q);
	assign row_next = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
	assign lim = (col_count_q > CNT_W'(COLS)) ? CNT_W'(COLS) : col_count_q;

	always_comb begin
		en_mask = '0;
		for (int i = 0; i < COLS; i++) begin
			en_mask[i] = lim > CNT_W'(i);
		end
	end

	always_comb begin
		done_row = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				phase_d = poll.tick ? PH_READ : PH_WAIT;
			end
			PH_READ: begin
				done_row = match;
				phase_d = match ? PH_STAB : PH_WAIT;
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	always_comb begin
		take.row = row_q;
		take.sample = sample;
		take.change = done_row ? ((sample ^ key_q[row_q]) & en_mask) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAB;
			row_q <= '0;
			prev_q <= '0;
			prev_valid_q <= 1'b0;
			col_count_q <= COL_COUNT_RESET;
			for (int r = 0; r < ROWS; r++) begin
				key_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				col_count_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_d;
				unique case (phase_q)
					PH_WAIT: begin
					end
					PH_READ: begin
						if (match) begin
							key_q[row_q] <= sample;
							row_q <= row_next;
						end else begin
							prev_q <= sample;
							prev_valid_q <= 1'b1;
						end
					end
					default: begin
						prev_valid_q <= 1'b0;
					end
				endcase
			end
		end
	end

	kps_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.take_valid (poll_valid),
		.take       (take),
		.take_ready (poll_ready),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt)
	);

	a_row_moves_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_READ && match |=> phase_q == PH_STAB && row_q != $past(row_q)
			|| ROWS == 1)
		else $error("completed row did not advance");

	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_WAIT && !poll.tick |=> phase_q == PH_WAIT)
		else $error("left wait without tick");

	a_stab_clears_prev: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q != PH_WAIT && phase_q != PH_READ |=> !prev_valid_q)
		else $error("previous sample still valid after stabilise");

endmodule

`default_nettype wire
